[sv/ulbm_pkg.sv]
`default_nettype none

package ulbm_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ByteLf    = 8'h0A;
  localparam logic [ByteW-1:0] ByteCr    = 8'h0D;
  localparam logic [ByteW-1:0] ByteC2    = 8'hC2;
  localparam logic [ByteW-1:0] ByteNel   = 8'h85;
  localparam logic [ByteW-1:0] ByteE2    = 8'hE2;
  localparam logic [ByteW-1:0] Byte80    = 8'h80;
  localparam logic [ByteW-1:0] ByteLs    = 8'hA8;
  localparam logic [ByteW-1:0] BytePs    = 8'hA9;

  // one result transaction
  typedef struct packed {
    logic line_break;
    logic crlf_carriage_return;
    logic past_end_position;
    logic last_of_run;
  } result_t;

endpackage

`default_nettype wire

[sv/ulbm_in_if.sv]
`default_nettype none

interface ulbm_in_if
  import ulbm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

[sv/ulbm_out_if.sv]
`default_nettype none

interface ulbm_out_if;
  logic valid;
  logic ready;
  logic line_break;
  logic crlf_carriage_return;
  logic past_end_position;
  logic last_of_run;

  modport source (output valid, output line_break, output crlf_carriage_return,
                  output past_end_position, output last_of_run, input ready);
  modport sink   (input valid, input line_break, input crlf_carriage_return,
                  input past_end_position, input last_of_run, output ready);
endinterface

`default_nettype wire

[sv/utf8_line_break_marker_core.sv]
`default_nettype none

// channel | dir | payload                                          | handshake
// in_ch   | in  | data_byte[7:0], end_of_text                      | valid/ready
// out_ch  | out | line_break, crlf_carriage_return,                | valid/ready
//         |     | past_end_position, last_of_run                   |
//
// a text byte's result appears one byte later (lookahead)
// an end transaction with a held byte gives two results in turn and blocks
// input for the second; others sustain one per cycle unless out_ch stalls
// rst_n is synchronous active low and clears the held byte and output valids
// a full output register is refilled in the cycle it is taken, so a stall on
// out_ch stalls in_ch only while no slot frees up

module utf8_line_break_marker_core
  import ulbm_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  ulbm_in_if.sink      in_ch,
  ulbm_out_if.source   out_ch
);

  // lookahead and multi-byte sequence state
  logic    held_valid_r, held_valid_nxt;
  logic    held_break_r, held_break_nxt;
  logic    held_is_cr_r, held_is_cr_nxt;
  logic    after_c2_r, after_c2_nxt;
  logic    after_e2_r, after_e2_nxt;
  logic    after_e2_80_r, after_e2_80_nxt;

  // output register and second-result slot for end transactions
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    pend_valid_r, pend_valid_nxt;
  logic    pend_break_r, pend_break_nxt;

  logic    slot_free;
  logic    in_fire;
  logic    brk;
  logic    is_lf;
  logic    crlf;

  // output slot frees when empty or taken this cycle
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = slot_free && !pend_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign is_lf = (in_ch.data_byte == ByteLf);
  assign brk   = ((in_ch.data_byte >= ByteLf) && (in_ch.data_byte <= ByteCr))
              || (after_c2_r && (in_ch.data_byte == ByteNel))
              || (after_e2_80_r && ((in_ch.data_byte == ByteLs)
                                  || (in_ch.data_byte == BytePs)));
  assign crlf  = held_is_cr_r && is_lf;

  always_comb begin
    held_valid_nxt  = held_valid_r;
    held_break_nxt  = held_break_r;
    held_is_cr_nxt  = held_is_cr_r;
    after_c2_nxt    = after_c2_r;
    after_e2_nxt    = after_e2_r;
    after_e2_80_nxt = after_e2_80_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_res_nxt     = out_res_r;
    pend_valid_nxt  = pend_valid_r;
    pend_break_nxt  = pend_break_r;

    if (pend_valid_r && slot_free) begin
      // second result of an end transaction: past-end position
      out_valid_nxt                    = 1'b1;
      out_res_nxt.line_break           = pend_break_r;
      out_res_nxt.crlf_carriage_return = 1'b0;
      out_res_nxt.past_end_position    = 1'b1;
      out_res_nxt.last_of_run          = 1'b1;
      pend_valid_nxt                   = 1'b0;
    end else if (in_fire) begin
      if (in_ch.end_of_text) begin
        out_valid_nxt                    = 1'b1;
        out_res_nxt.crlf_carriage_return = 1'b0;
        if (held_valid_r) begin
          // flush held byte, past-end result follows next
          out_res_nxt.line_break        = held_break_r;
          out_res_nxt.past_end_position = 1'b0;
          out_res_nxt.last_of_run       = 1'b0;
          pend_valid_nxt                = 1'b1;
          pend_break_nxt                = !held_break_r;
        end else begin
          // empty stream
          out_res_nxt.line_break        = 1'b0;
          out_res_nxt.past_end_position = 1'b1;
          out_res_nxt.last_of_run       = 1'b1;
        end
        held_valid_nxt  = 1'b0;
        held_break_nxt  = 1'b0;
        held_is_cr_nxt  = 1'b0;
        after_c2_nxt    = 1'b0;
        after_e2_nxt    = 1'b0;
        after_e2_80_nxt = 1'b0;
      end else begin
        if (held_valid_r) begin
          // result for the held byte, now that its successor is known
          out_valid_nxt                    = 1'b1;
          out_res_nxt.line_break           = held_break_r && !crlf;
          out_res_nxt.crlf_carriage_return = crlf;
          out_res_nxt.past_end_position    = 1'b0;
          out_res_nxt.last_of_run          = 1'b1;
        end
        held_valid_nxt  = 1'b1;
        held_break_nxt  = brk;
        held_is_cr_nxt  = (in_ch.data_byte == ByteCr);
        after_e2_80_nxt = after_e2_r && (in_ch.data_byte == Byte80);
        after_c2_nxt    = (in_ch.data_byte == ByteC2);
        after_e2_nxt    = (in_ch.data_byte == ByteE2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_break_r  <= 1'b0;
      held_is_cr_r  <= 1'b0;
      after_c2_r    <= 1'b0;
      after_e2_r    <= 1'b0;
      after_e2_80_r <= 1'b0;
      out_valid_r   <= 1'b0;
      pend_valid_r  <= 1'b0;
    end else begin
      held_valid_r  <= held_valid_nxt;
      held_break_r  <= held_break_nxt;
      held_is_cr_r  <= held_is_cr_nxt;
      after_c2_r    <= after_c2_nxt;
      after_e2_r    <= after_e2_nxt;
      after_e2_80_r <= after_e2_80_nxt;
      out_valid_r   <= out_valid_nxt;
      pend_valid_r  <= pend_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_res_r    <= out_res_nxt;
    pend_break_r <= pend_break_nxt;
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.line_break           = out_res_r.line_break;
  assign out_ch.crlf_carriage_return = out_res_r.crlf_carriage_return;
  assign out_ch.past_end_position    = out_res_r.past_end_position;
  assign out_ch.last_of_run          = out_res_r.last_of_run;

endmodule

`default_nettype wire
